// ===== src/dlf_pkg.sv =====
// Package for the decimating low-pass filter unit.
// Holds the sequencer state type, register indexes, mode values and fixed widths.
// No dependencies.
package dlf_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned WLEN_W     = 9;
  localparam int unsigned DECIM_W    = 16;
  localparam int unsigned DIVISOR_W  = 10;
  localparam int unsigned FRAC_BITS  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd2;

  localparam logic MODE_BOXCAR      = 1'b0;
  localparam logic MODE_EXPONENTIAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_PUSH
  } state_e;

endpackage

// ===== src/decimating_lowpass_filter_unit.sv =====
// Decimating low-pass filter unit: boxcar moving average or exponential average.
// Depends on dlf_pkg and dlf_ram.
//
// One sample is taken per request and the unit is busy until it is done. In
// boxcar mode a sample that gives no result only updates the window and its
// running sum. Every other sample runs the shared bit-serial divider, which
// produces one quotient bit per cycle. A sample that gives a result also waits
// while the output register still holds an earlier result. A finished result
// waits in an output register, so a new sample is taken while it is still
// pending. A write to any of the three defined configuration registers restarts
// the window fill; a write to the unused index does not. The window memory
// needs no clearing after reset.
module decimating_lowpass_filter_unit #(
  parameter int unsigned WINDOW_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dlf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: filtered.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata
);

  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned AW      = $clog2(WINDOW_DEPTH);
  localparam int unsigned LEN_W   = dlf_pkg::WLEN_W;
  localparam int unsigned SUM_W   = SAMPLE_BITS + LEN_W;
  localparam int unsigned ACC_W   = SAMPLE_BITS + dlf_pkg::FRAC_BITS;
  localparam int unsigned DIV_W   = ACC_W + 1;
  localparam int unsigned DVS_W   = dlf_pkg::DIVISOR_W;
  localparam int unsigned CNT_W   = $clog2(DIV_W);
  localparam int unsigned CMP_W   = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int unsigned LEN_MAX = (WINDOW_DEPTH < 511) ? WINDOW_DEPTH : 511;

  dlf_pkg::state_e state_q, state_d;

  logic [LEN_W-1:0]             wlen_q, wlen_d;
  logic [dlf_pkg::DECIM_W-1:0]  decim_q, decim_d;
  logic                         mode_q, mode_d;
  logic [AW-1:0]                wp_q, wp_d;
  logic signed [SUM_W-1:0]      sum_q, sum_d;
  logic [LEN_W-1:0]             fill_q, fill_d;
  logic [dlf_pkg::DECIM_W-1:0]  dcnt_q, dcnt_d;
  logic signed [ACC_W-1:0]      acc_q, acc_d;
  logic                         seeded_q, seeded_d;
  logic                         emit_q, emit_d;
  logic                         neg_q, neg_d;
  logic [DVS_W-1:0]             dvs_q, dvs_d;
  logic [DVS_W-1:0]             rem_q, rem_d;
  logic [DIV_W-1:0]             quo_q, quo_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic signed [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic [SAMPLE_BITS-1:0]       res_q, res_d;
  logic [SAMPLE_BITS-1:0]       out_q, out_d;
  logic                         out_valid_q, out_valid_d;

  logic [LEN_W-1:0]             len;
  logic [dlf_pkg::DECIM_W-1:0]  dec_eff;
  logic                         full;
  logic [SAMPLE_BITS-1:0]       old_smp;
  logic signed [SUM_W-1:0]      sum_new;
  logic signed [ACC_W-1:0]      scaled;
  logic signed [ACC_W-1:0]      base;
  logic signed [DIV_W-1:0]      dividend;
  logic [DIV_W-1:0]             dvd_mag;
  logic [CMP_W-1:0]             wp_inc;
  logic [LEN_W-1:0]             fill_inc;
  logic [dlf_pkg::DECIM_W-1:0]  dcnt_inc;
  logic [DVS_W:0]               rem_shift;
  logic                         rem_ge;
  logic signed [DIV_W-1:0]      quo_s;
  logic signed [ACC_W-1:0]      acc_new;
  logic                         in_acc;
  logic                         out_load;
  logic                         ram_we;

  assign len = (wlen_q == '0) ? LEN_W'(1) :
               ((wlen_q > LEN_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : wlen_q);
  assign dec_eff = (decim_q == '0) ? dlf_pkg::DECIM_W'(1) : decim_q;

  assign s_axis_tready = (state_q == dlf_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_q);
  assign out_load      = (state_q == dlf_pkg::ST_PUSH) && (!out_valid_q || m_axis_tready);
  assign ram_we        = (state_q == dlf_pkg::ST_LOAD) && (mode_q == dlf_pkg::MODE_BOXCAR);

  dlf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(smp_q),
    .raddr_i(wp_q),
    .rdata_o(old_smp)
  );

  assign full     = (fill_q >= len);
  assign sum_new  = sum_q - (full ? SUM_W'(signed'(old_smp)) : SUM_W'(0))
                    + SUM_W'(smp_q);
  assign scaled   = {smp_q, {dlf_pkg::FRAC_BITS{1'b0}}};
  assign base     = seeded_q ? acc_q : scaled;
  assign dividend = (mode_q == dlf_pkg::MODE_BOXCAR) ? DIV_W'(sum_new)
                                                     : (DIV_W'(scaled) - DIV_W'(base));
  assign dvd_mag  = dividend[DIV_W-1] ? (~dividend + DIV_W'(1)) : dividend;
  assign wp_inc   = CMP_W'(wp_q) + CMP_W'(1);
  assign fill_inc = fill_q + LEN_W'(1);
  assign dcnt_inc = dcnt_q + dlf_pkg::DECIM_W'(1);

  assign rem_shift = {rem_q, quo_q[DIV_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dvs_q});
  assign quo_s     = neg_q ? -signed'(quo_q) : signed'(quo_q);
  assign acc_new   = acc_q + ACC_W'(quo_s);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dlf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = dlf_pkg::ST_LOAD;
        end
      end
      dlf_pkg::ST_LOAD: begin
        if (mode_q == dlf_pkg::MODE_BOXCAR && !emit_d) begin
          state_d = dlf_pkg::ST_IDLE;
        end else begin
          state_d = dlf_pkg::ST_DIV;
        end
      end
      dlf_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = dlf_pkg::ST_FIN;
        end
      end
      dlf_pkg::ST_FIN: begin
        state_d = emit_q ? dlf_pkg::ST_PUSH : dlf_pkg::ST_IDLE;
      end
      dlf_pkg::ST_PUSH: begin
        if (out_load) begin
          state_d = dlf_pkg::ST_IDLE;
        end
      end
      default: state_d = dlf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    wlen_d      = wlen_q;
    decim_d     = decim_q;
    mode_d      = mode_q;
    wp_d        = wp_q;
    sum_d       = sum_q;
    fill_d      = fill_q;
    dcnt_d      = dcnt_q;
    acc_d       = acc_q;
    seeded_d    = seeded_q;
    emit_d      = emit_q;
    neg_d       = neg_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    smp_d       = smp_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    case (state_q)
      dlf_pkg::ST_IDLE: begin
        if (in_acc) begin
          smp_d = s_axis_tdata[SAMPLE_BITS-1:0];
        end
      end
      dlf_pkg::ST_LOAD: begin
        neg_d = dividend[DIV_W-1];
        quo_d = dvd_mag;
        rem_d = '0;
        cnt_d = CNT_W'(DIV_W - 1);
        if (mode_q == dlf_pkg::MODE_BOXCAR) begin
          dvs_d = DVS_W'(len);
          sum_d = sum_new;
          wp_d  = (wp_inc >= CMP_W'(len)) ? '0 : wp_inc[AW-1:0];
          if (!full) begin
            fill_d = fill_inc;
            emit_d = (fill_inc >= len);
            if (fill_inc >= len) begin
              dcnt_d = '0;
            end
          end else if (dcnt_inc >= dec_eff) begin
            dcnt_d = '0;
            emit_d = 1'b1;
          end else begin
            dcnt_d = dcnt_inc;
            emit_d = 1'b0;
          end
        end else begin
          dvs_d    = DVS_W'(len) + DVS_W'(1);
          acc_d    = base;
          seeded_d = 1'b1;
          if (dcnt_inc >= dec_eff) begin
            dcnt_d = '0;
            emit_d = 1'b1;
          end else begin
            dcnt_d = dcnt_inc;
            emit_d = 1'b0;
          end
        end
      end
      dlf_pkg::ST_DIV: begin
        cnt_d = cnt_q - CNT_W'(1);
        if (rem_ge) begin
          rem_d = DVS_W'(rem_shift - {1'b0, dvs_q});
        end else begin
          rem_d = rem_shift[DVS_W-1:0];
        end
        quo_d = {quo_q[DIV_W-2:0], rem_ge};
      end
      dlf_pkg::ST_FIN: begin
        if (mode_q == dlf_pkg::MODE_BOXCAR) begin
          res_d = quo_s[SAMPLE_BITS-1:0];
        end else begin
          acc_d = acc_new;
          res_d = acc_new[ACC_W-1:dlf_pkg::FRAC_BITS];
        end
      end
      dlf_pkg::ST_PUSH: begin
        if (out_load) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase

    if (cfg_we_i && (cfg_idx_i inside {dlf_pkg::REG_WINDOW_LENGTH, dlf_pkg::REG_DECIMATION,
                                       dlf_pkg::REG_MODE})) begin
      case (cfg_idx_i)
        dlf_pkg::REG_WINDOW_LENGTH: wlen_d  = cfg_wdata_i[LEN_W-1:0];
        dlf_pkg::REG_DECIMATION:    decim_d = cfg_wdata_i[dlf_pkg::DECIM_W-1:0];
        dlf_pkg::REG_MODE:          mode_d  = cfg_wdata_i[0];
        default: ;
      endcase
      wp_d     = '0;
      sum_d    = '0;
      fill_d   = '0;
      dcnt_d   = '0;
      acc_d    = '0;
      seeded_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlf_pkg::ST_IDLE;
      wlen_q      <= LEN_W'(16);
      decim_q     <= dlf_pkg::DECIM_W'(1);
      mode_q      <= dlf_pkg::MODE_BOXCAR;
      wp_q        <= '0;
      sum_q       <= '0;
      fill_q      <= '0;
      dcnt_q      <= '0;
      acc_q       <= '0;
      seeded_q    <= 1'b0;
      emit_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wlen_q      <= wlen_d;
      decim_q     <= decim_d;
      mode_q      <= mode_d;
      wp_q        <= wp_d;
      sum_q       <= sum_d;
      fill_q      <= fill_d;
      dcnt_q      <= dcnt_d;
      acc_q       <= acc_d;
      seeded_q    <= seeded_d;
      emit_q      <= emit_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    smp_q <= smp_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

// ===== src/dlf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the boxcar sample window. No dependencies.
module dlf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/tb_decimating_lowpass_filter_unit.sv =====
`timescale 1ns / 100ps
// Testbench for decimating_lowpass_filter_unit: directed and random sample requests in both
// filter modes, each output checked against a behavioral model of the two averages.
// Depends on dlf_pkg and the unit's RTL.
module tb_decimating_lowpass_filter_unit;

  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned HIST_DEPTH     = 256;
  localparam int unsigned SETTLE_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned RANDOM_SAMPLES = 1225;
  localparam logic [dlf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [dlf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [dlf_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [SAMPLE_W-1:0]            s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [SAMPLE_W-1:0]            m_axis_tdata;

  logic [dlf_pkg::WLEN_W-1:0]  win_len_reg;
  logic [dlf_pkg::DECIM_W-1:0] decim_reg;
  logic                        mode_reg;
  logic signed [SAMPLE_W-1:0]  window_hist [HIST_DEPTH];
  int unsigned                 hist_ptr;
  longint                      box_sum;
  int unsigned                 fill_cnt;
  int unsigned                 decim_cnt;
  longint                      exp_acc;
  bit                          exp_seeded;

  logic signed [SAMPLE_W-1:0] expected_filtered [$];
  int unsigned samples_sent;
  int unsigned outputs_checked;
  int unsigned mismatches;
  int unsigned settings_applied;
  bit          src_idle;
  bit          sink_idle;

  decimating_lowpass_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic void restart_filter();
    hist_ptr   = 0;
    box_sum    = 0;
    fill_cnt   = 0;
    decim_cnt  = 0;
    exp_acc    = 0;
    exp_seeded = 1'b0;
  endfunction

  function automatic void update_register(input logic [dlf_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [dlf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      dlf_pkg::REG_WINDOW_LENGTH: win_len_reg = data[dlf_pkg::WLEN_W-1:0];
      dlf_pkg::REG_DECIMATION:    decim_reg = data[dlf_pkg::DECIM_W-1:0];
      dlf_pkg::REG_MODE:          mode_reg = data[0];
      default:                    return;
    endcase
    restart_filter();
  endfunction

  function automatic bit compute_filtered(input logic signed [SAMPLE_W-1:0] s,
                                          output logic signed [SAMPLE_W-1:0] y);
    int unsigned len;
    int unsigned dec;
    longint scaled;
    len = (win_len_reg == 0) ? 1 : ((win_len_reg > HIST_DEPTH) ? HIST_DEPTH : win_len_reg);
    dec = (decim_reg == 0) ? 1 : decim_reg;
    y = '0;
    if (mode_reg == dlf_pkg::MODE_BOXCAR) begin
      if (fill_cnt >= len) box_sum -= window_hist[hist_ptr];
      window_hist[hist_ptr] = s;
      box_sum += s;
      hist_ptr = (hist_ptr + 1 >= len) ? 0 : hist_ptr + 1;
      if (fill_cnt < len) begin
        fill_cnt++;
        if (fill_cnt < len) return 1'b0;
      end else begin
        decim_cnt++;
        if (decim_cnt < dec) return 1'b0;
      end
      decim_cnt = 0;
      y = SAMPLE_W'(box_sum / longint'(len));
    end else begin
      scaled = longint'(s) * (longint'(1) << dlf_pkg::FRAC_BITS);
      if (!exp_seeded) begin
        exp_acc = scaled;
        exp_seeded = 1'b1;
      end
      exp_acc += (scaled - exp_acc) / (longint'(len) + 1);
      decim_cnt++;
      if (decim_cnt < dec) return 1'b0;
      decim_cnt = 0;
      y = SAMPLE_W'(exp_acc >>> dlf_pkg::FRAC_BITS);
    end
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_W'($urandom_range(0, 512)) - 24'sd256;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int unsigned gap;
    logic signed [SAMPLE_W-1:0] y;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    if (compute_filtered(s, y)) expected_filtered.push_back(y);
    samples_sent++;
  endtask

  // A sample that yields no output may still be in the divider after the last result.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dlf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dlf_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    update_register(idx, data);
  endtask

  task automatic configure(input logic [dlf_pkg::CFG_DATA_W-1:0] wl_word,
                           input logic [dlf_pkg::CFG_DATA_W-1:0] dec_word,
                           input logic [dlf_pkg::CFG_DATA_W-1:0] mode_word);
    wait_quiet();
    write_reg(dlf_pkg::REG_WINDOW_LENGTH, wl_word);
    write_reg(dlf_pkg::REG_DECIMATION, dec_word);
    write_reg(dlf_pkg::REG_MODE, mode_word);
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic test_boxcar_extremes();
    logic signed [SAMPLE_W-1:0] seq [8] = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                                            -24'sd1, 24'sd0, 24'sd1, -24'sd1};
    configure(16'd2, 16'd1, {15'd0, dlf_pkg::MODE_BOXCAR});
    foreach (seq[i]) send_sample(seq[i]);
    // A zero window length behaves as a window of one.
    configure(16'd0, 16'd1, {15'd0, dlf_pkg::MODE_BOXCAR});
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(-24'sd1);
  endtask

  task automatic test_exponential_extremes();
    configure(16'd1, 16'd0, {15'd0, dlf_pkg::MODE_EXPONENTIAL});
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample(24'sd0);
  endtask

  task automatic test_restart_rules();
    configure(16'd3, 16'd1, {15'd0, dlf_pkg::MODE_BOXCAR});
    send_sample(24'sd100);
    send_sample(-24'sd200);
    wait_quiet();
    write_reg(REG_UNUSED, dlf_pkg::CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    send_sample(24'sd300);
    send_sample(-24'sd7);
    wait_quiet();
    write_reg(dlf_pkg::REG_WINDOW_LENGTH, 16'd3);
    cfg_we_i <= 1'b0;
    send_sample(24'sd5);
    send_sample(24'sd6);
    send_sample(-24'sd20);
  endtask

  task automatic test_random_phases();
    int unsigned phase;
    int unsigned n;
    int unsigned start;
    logic [dlf_pkg::WLEN_W-1:0]  wl;
    logic [dlf_pkg::DECIM_W-1:0] dec;
    logic                        md;
    phase = 0;
    start = samples_sent;
    while (samples_sent - start < RANDOM_SAMPLES) begin
      md = 1'($urandom_range(0, 1));
      n  = $urandom_range(20, 70);
      if ($urandom_range(0, 7) == 0) dec = dlf_pkg::DECIM_W'($urandom_range(0, 40));
      else dec = dlf_pkg::DECIM_W'($urandom_range(1, 4));
      case ($urandom_range(0, 3))
        0:       wl = dlf_pkg::WLEN_W'($urandom_range(0, 4));
        3:       wl = dlf_pkg::WLEN_W'($urandom_range(13, 48));
        default: wl = dlf_pkg::WLEN_W'($urandom_range(1, 12));
      endcase
      case (phase)
        2: begin
          wl  = 9'd256;
          dec = 16'd1;
          md  = dlf_pkg::MODE_BOXCAR;
          n   = 280;
        end
        4: begin
          wl = 9'h1FF;
          md = dlf_pkg::MODE_EXPONENTIAL;
        end
        6: begin
          wl  = dlf_pkg::WLEN_W'($urandom_range(257, 511));
          dec = dlf_pkg::DECIM_W'($urandom_range(0, 2));
          md  = dlf_pkg::MODE_BOXCAR;
          n   = 290;
        end
        9: dec = 16'hFFFF;
        default: ;
      endcase
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      configure({7'($urandom), wl}, dec, {15'($urandom), md});
      repeat (n) send_sample(draw_sample());
      phase++;
    end
  endtask

  initial begin : output_checker
    int unsigned stall;
    logic signed [SAMPLE_W-1:0] want;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = sink_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      outputs_checked++;
      if (expected_filtered.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected output %0d with no result pending", $signed(m_axis_tdata));
        end
      end else begin
        want = expected_filtered.pop_front();
        if (m_axis_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("filtered mismatch: expected %0d, got %0d", want, $signed(m_axis_tdata));
          end
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= dlf_pkg::REG_WINDOW_LENGTH;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    samples_sent     = 0;
    outputs_checked  = 0;
    mismatches       = 0;
    settings_applied = 0;
    win_len_reg = 9'd16;
    decim_reg   = 16'd1;
    mode_reg    = dlf_pkg::MODE_BOXCAR;
    restart_filter();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boxcar_extremes();
    test_exponential_extremes();
    test_restart_rules();
    test_random_phases();
    wait_quiet();
    $display("Ran %0d sample requests under %0d register settings in both filter modes.",
             samples_sent, settings_applied);
    $display("Compared %0d filtered outputs; %0d mismatches.", outputs_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
